// ===== rtl/lbe_pkg.sv =====
package lbe_pkg;

  localparam int LABEL_W    = 16;
  localparam int COORD_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_BLK    = 3;   // pixels that one item can finish
  localparam int MASK_W     = 4 * NUM_BLK;
  localparam int MASK_IDX_W = $clog2(MASK_W);

  typedef logic [LABEL_W-1:0]    label_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [MASK_W-1:0]     edge_mask_t;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_BOTTOM = 2'd3
  } side_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_BACKGROUND   = 2'd2;

endpackage

// ===== rtl/lbe_if.sv =====
interface lbe_in_if;
  logic            valid;
  logic            ready;
  lbe_pkg::label_t pixel_label;

  modport source (output valid, output pixel_label, input ready);
  modport sink   (input valid, input pixel_label, output ready);
endinterface

interface lbe_out_if;
  logic            valid;
  logic            ready;
  lbe_pkg::label_t edge_label;
  lbe_pkg::coord_t start_x;
  lbe_pkg::coord_t start_y;
  lbe_pkg::coord_t end_x;
  lbe_pkg::coord_t end_y;
  lbe_pkg::side_t  side;
  logic            last_of_run;

  modport source (output valid, output edge_label, output start_x, output start_y,
                  output end_x, output end_y, output side, output last_of_run,
                  input ready);
  modport sink   (input valid, input edge_label, input start_x, input start_y,
                  input end_x, input end_y, input side, input last_of_run,
                  output ready);
endinterface

interface lbe_cfg_if;
  logic               valid;
  logic               ready;
  lbe_pkg::cfg_idx_t  reg_index;
  lbe_pkg::cfg_data_t wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/label_boundary_edge_extract.sv =====
// Channel   Dir  Payload                                              Transaction
// cfg_ch    in   reg_index, wdata                                     valid & ready
// in_ch     in   pixel_label                                          valid & ready
// out_ch    out  edge_label, start/end x/y, side, last_of_run         valid & ready
//
// Rate: one pixel per cycle while no edges wait in the edge register; edges leave one at a time,
//   up to 12 per pixel, through the single result port. The first edge of a pixel passes the
//   line store read register, then the edge register.
// Both line stores are read, and one of them written, in the pixel's transaction cycle; no clear pass.
// Reset: synchronous, active low; position, store select and edge register cleared.
// Stalls: out_ch.ready low holds the edge register; one pixel waits behind it, then in_ch stalls.
module label_boundary_edge_extract #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  lbe_cfg_if.sink   cfg_ch,
  lbe_in_if.sink    in_ch,
  lbe_out_if.source out_ch
);
  import lbe_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef logic [XW-1:0] col_t;
  typedef logic [YW-1:0] row_t;

  // configuration
  coord_t width_r;
  coord_t height_r;
  label_t bg_r;
  col_t   w_last;
  row_t   h_last;

  // position and line store select
  col_t   col_r;
  row_t   row_r;
  logic   sel_r;
  label_t recent0_r;
  label_t recent1_r;

  // line stores
  label_t mem_a [MAX_WIDTH];
  label_t mem_b [MAX_WIDTH];
  label_t a_rd0_r, a_rd1_r, b_rd0_r, b_rd1_r;
  col_t   rd_addr1;

  // read stage
  logic   s1_v_r;
  label_t s1_cur_r;
  col_t   s1_x_r;
  row_t   s1_y_r;
  logic   s1_x0_r, s1_x1_r, s1_y0_r, s1_y1_r, s1_lcol_r, s1_lrow_r, s1_sel_r;
  label_t s1_r0_r, s1_r1_r;
  label_t prev_m1_r;

  // edge register
  edge_mask_t em_mask_r;
  edge_mask_t em_mask_nxt;
  label_t     em_lab_r [NUM_BLK];
  coord_t     em_px_r  [NUM_BLK];
  coord_t     em_py_r  [NUM_BLK];

  logic       in_fire, out_fire, cfg_fire, load, em_free, em_last;
  logic       size_write;
  label_t     prev0, prev1, older0;
  edge_mask_t mask_new;
  label_t     blk_lab [NUM_BLK];
  coord_t     blk_px  [NUM_BLK];
  coord_t     blk_py  [NUM_BLK];
  coord_t     xc, yc;
  edge_mask_t lowest;
  logic [MASK_IDX_W-1:0] low_idx;
  label_t     o_lab;
  coord_t     o_px, o_py;
  side_t      o_side;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign size_write   = cfg_fire &&
                        (cfg_ch.reg_index == REG_IMAGE_WIDTH ||
                         cfg_ch.reg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= COORD_W'(1024);
      height_r <= COORD_W'(1024);
      bg_r     <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_ch.reg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_ch.wdata[COORD_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_ch.wdata[COORD_W-1:0];
        REG_BACKGROUND:   bg_r     <= cfg_ch.wdata[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (width_r == '0)
      w_last = '0;
    else if (32'(width_r) > MAX_WIDTH)
      w_last = XW'(MAX_WIDTH - 1);
    else
      w_last = XW'(width_r - 1'b1);

    if (height_r == '0)
      h_last = '0;
    else if (32'(height_r) > MAX_HEIGHT)
      h_last = YW'(MAX_HEIGHT - 1);
    else
      h_last = YW'(height_r - 1'b1);
  end

  // ---------------- input side ----------------
  assign in_ch.ready = !s1_v_r || load;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rd_addr1    = col_r + 1'b1;   // wraps at the top; value unused there

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      sel_r     <= 1'b0;
      recent0_r <= '0;
      recent1_r <= '0;
    end else if (size_write) begin
      col_r <= '0;
      row_r <= '0;
      sel_r <= 1'b0;
    end else if (in_fire) begin
      recent0_r <= in_ch.pixel_label;
      recent1_r <= recent0_r;
      if (col_r == w_last) begin
        col_r <= '0;
        if (row_r == h_last) begin
          row_r <= '0;
          sel_r <= 1'b0;
        end else begin
          row_r <= row_r + 1'b1;
          sel_r <= !sel_r;
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Store select 0: a holds the previous row, b the row before and takes the new one.
  // Same-entry write and read in one cycle returns the old entry, as needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (sel_r)
        mem_a[col_r] <= in_ch.pixel_label;
      a_rd0_r <= mem_a[col_r];
      a_rd1_r <= mem_a[rd_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!sel_r)
        mem_b[col_r] <= in_ch.pixel_label;
      b_rd0_r <= mem_b[col_r];
      b_rd1_r <= mem_b[rd_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r  <= in_ch.pixel_label;
      s1_x_r    <= col_r;
      s1_y_r    <= row_r;
      s1_x0_r   <= (col_r == '0);
      s1_x1_r   <= (col_r == XW'(1));
      s1_y0_r   <= (row_r == '0);
      s1_y1_r   <= (row_r == YW'(1));
      s1_lcol_r <= (col_r == w_last);
      s1_lrow_r <= (row_r == h_last);
      s1_sel_r  <= sel_r;
      s1_r0_r   <= recent0_r;
      s1_r1_r   <= recent1_r;
    end
    if (load)
      prev_m1_r <= prev0;
  end

  // ---------------- edge decisions ----------------
  assign prev0  = s1_sel_r ? b_rd0_r : a_rd0_r;
  assign prev1  = s1_sel_r ? b_rd1_r : a_rd1_r;
  assign older0 = s1_sel_r ? a_rd0_r : b_rd0_r;
  assign xc     = COORD_W'(s1_x_r);
  assign yc     = COORD_W'(s1_y_r);

  always_comb begin
    mask_new = '0;

    // pixel above, finished by this one
    blk_lab[0] = prev0;
    blk_px[0]  = xc;
    blk_py[0]  = yc - 1'b1;
    if (!s1_y0_r && prev0 != bg_r)
      mask_new[3:0] = {s1_cur_r != prev0,
                       s1_y1_r || older0 != prev0,
                       s1_lcol_r || prev1 != prev0,
                       s1_x0_r || prev_m1_r != prev0};

    // left neighbor in the bottom row
    blk_lab[1] = s1_r0_r;
    blk_px[1]  = xc - 1'b1;
    blk_py[1]  = yc;
    if (s1_lrow_r && !s1_x0_r && s1_r0_r != bg_r)
      mask_new[7:4] = {1'b1,
                       s1_y0_r || prev_m1_r != s1_r0_r,
                       s1_cur_r != s1_r0_r,
                       s1_x1_r || s1_r1_r != s1_r0_r};

    // final pixel of the frame
    blk_lab[2] = s1_cur_r;
    blk_px[2]  = xc;
    blk_py[2]  = yc;
    if (s1_lrow_r && s1_lcol_r && s1_cur_r != bg_r)
      mask_new[11:8] = {1'b1,
                        s1_y0_r || prev0 != s1_cur_r,
                        1'b1,
                        s1_x0_r || s1_r0_r != s1_cur_r};
  end

  // ---------------- edge register ----------------
  assign lowest   = em_mask_r & (~em_mask_r + 1'b1);
  assign em_last  = (em_mask_r & (em_mask_r - 1'b1)) == '0;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign em_free  = (em_mask_r == '0) || (out_ch.ready && em_last);
  assign load     = s1_v_r && em_free;

  always_comb begin
    em_mask_nxt = em_mask_r;
    if (load)
      em_mask_nxt = mask_new;
    else if (out_fire)
      em_mask_nxt = em_mask_r & ~lowest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      em_mask_r <= '0;
    else
      em_mask_r <= em_mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_BLK; i++) begin
        em_lab_r[i] <= blk_lab[i];
        em_px_r[i]  <= blk_px[i];
        em_py_r[i]  <= blk_py[i];
      end
    end
  end

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < MASK_W; i++)
      if (lowest[i])
        low_idx = low_idx | MASK_IDX_W'(i);
  end

  always_comb begin
    case (low_idx[MASK_IDX_W-1:2])
      2'd1: begin
        o_lab = em_lab_r[1];
        o_px  = em_px_r[1];
        o_py  = em_py_r[1];
      end
      2'd2: begin
        o_lab = em_lab_r[2];
        o_px  = em_px_r[2];
        o_py  = em_py_r[2];
      end
      default: begin
        o_lab = em_lab_r[0];
        o_px  = em_px_r[0];
        o_py  = em_py_r[0];
      end
    endcase
    o_side = side_t'(low_idx[1:0]);
  end

  // region kept on the left, y grows downward
  always_comb begin
    unique case (o_side)
      SIDE_LEFT: begin
        out_ch.start_x = o_px;
        out_ch.start_y = o_py;
        out_ch.end_x   = o_px;
        out_ch.end_y   = o_py + 1'b1;
      end
      SIDE_RIGHT: begin
        out_ch.start_x = o_px + 1'b1;
        out_ch.start_y = o_py + 1'b1;
        out_ch.end_x   = o_px + 1'b1;
        out_ch.end_y   = o_py;
      end
      SIDE_TOP: begin
        out_ch.start_x = o_px + 1'b1;
        out_ch.start_y = o_py;
        out_ch.end_x   = o_px;
        out_ch.end_y   = o_py;
      end
      default: begin
        out_ch.start_x = o_px;
        out_ch.start_y = o_py + 1'b1;
        out_ch.end_x   = o_px + 1'b1;
        out_ch.end_y   = o_py + 1'b1;
      end
    endcase
  end

  assign out_ch.valid       = em_mask_r != '0;
  assign out_ch.edge_label  = o_lab;
  assign out_ch.side        = o_side;
  assign out_ch.last_of_run = em_last;

  // ---------------- checks ----------------
  a_size_restart: assert property (@(posedge clk) disable iff (!rst_n)
    size_write |=> (col_r == '0 && row_r == '0 && !sel_r))
    else $error("frame position not restarted after size write");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    !size_write |=> (col_r <= w_last))
    else $error("column position beyond image width");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && col_r == w_last && row_r == h_last) |=> (row_r == '0 && !sel_r))
    else $error("frame did not wrap after final pixel");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("edges of a pixel dropped before last_of_run");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(em_mask_r))
    else $error("edge register changed while output stalled");

endmodule
